// File: rtl/tsas_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the touch sample averaging and scaling block.
package tsas_pkg;

	localparam int unsigned RAW_W = 16;
	localparam int unsigned SPAN_W = 9;
	localparam int unsigned COORD_W = 9;
	localparam int unsigned MUL_CNT_W = 4;

	localparam int unsigned DIVD_W = 25;
	localparam int unsigned DIVS_W = 16;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [COORD_W-1:0] SCREEN_LONG = 9'd320;
	localparam logic [COORD_W-1:0] SCREEN_SHORT = 9'd240;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MAX_X = 3'd1;
	localparam logic [2:0] REG_MIN_Y = 3'd2;
	localparam logic [2:0] REG_MAX_Y = 3'd3;
	localparam logic [2:0] REG_SCALE_X = 3'd4;
	localparam logic [2:0] REG_SCALE_Y = 3'd5;
	localparam logic [2:0] REG_ROTATION = 3'd6;

	localparam logic [1:0] ROT_NORMAL = 2'd0;
	localparam logic [1:0] ROT_LEFT = 2'd1;
	localparam logic [1:0] ROT_RIGHT = 2'd2;
	localparam logic [1:0] ROT_FLIP = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_CLAMP,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/tsas_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module tsas_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tsas_pkg::DIVD_W-1:0]       dividend,
	input  logic [tsas_pkg::DIVS_W-1:0]       divisor,
	output logic [tsas_pkg::DIVD_W-1:0]       quotient,
	output tsas_pkg::div_stat_t               stat
);

	localparam logic [tsas_pkg::DIV_CNT_W-1:0] LAST_STEP =
		tsas_pkg::DIV_CNT_W'(tsas_pkg::DIVD_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic [tsas_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [tsas_pkg::DIVS_W-1:0]       rem_q;
	logic [tsas_pkg::DIVS_W-1:0]       dsr_q;
	logic [tsas_pkg::DIVD_W-1:0]       quo_q;
	logic [tsas_pkg::DIVS_W:0]         trial;
	logic [tsas_pkg::DIVS_W:0]         diff;
	logic                              fits;

	always_comb begin
		trial = {rem_q, quo_q[tsas_pkg::DIVD_W-1]};
		diff = trial - {1'b0, dsr_q};
		fits = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[tsas_pkg::DIVS_W-1:0] : trial[tsas_pkg::DIVS_W-1:0];
			quo_q <= {quo_q[tsas_pkg::DIVD_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/touch_sample_average_scale.sv
`timescale 1ns / 1ps
// Top level: touch sample averaging, calibration clamp, scaling and rotation.
//
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tuser pressed, s_tdata x then y reading
// m_*       out        m_tvalid / m_tready   m_tuser status, m_tdata x then y coordinate
// cfg_*     in         cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// A sample that does not complete a set only adds to the sums; a release clears them.
// The completing sample runs per axis one serial divide of the sum (25 steps), then,
// if its max is above its min, a 9-step shift-add multiply and a second 25-step divide.
// Reset clears the sums, the count and the output valid; registers take their defaults.
// A held result stalls the input until the output register is taken.
module touch_sample_average_scale #(
	parameter int unsigned SAMPLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_reading [15:0], y_reading [31:16]
	input  logic        s_tuser,   // pressed
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // x_coord [8:0], y_coord [17:9], zero fill
	output logic        m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned CNT_W = $clog2(SAMPLES);
	localparam int unsigned SUM_W = tsas_pkg::RAW_W + CNT_W;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);
	localparam logic [tsas_pkg::MUL_CNT_W-1:0] LAST_MUL =
		tsas_pkg::MUL_CNT_W'(tsas_pkg::SPAN_W - 1);

	tsas_pkg::state_t                  state_q;
	tsas_pkg::state_t                  state_nx;

	logic [tsas_pkg::RAW_W-1:0]        min_x_q;
	logic [tsas_pkg::RAW_W-1:0]        max_x_q;
	logic [tsas_pkg::RAW_W-1:0]        min_y_q;
	logic [tsas_pkg::RAW_W-1:0]        max_y_q;
	logic [7:0]                        scale_x_q;
	logic [8:0]                        scale_y_q;
	logic [1:0]                        rot_q;

	logic [SUM_W-1:0]                  x_sum_q;
	logic [SUM_W-1:0]                  y_sum_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              axis_q;

	logic [tsas_pkg::RAW_W-1:0]        avg_q;
	logic [tsas_pkg::DIVD_W-1:0]       mcand_q;
	logic [tsas_pkg::SPAN_W-1:0]       mplier_q;
	logic [tsas_pkg::DIVD_W-1:0]       prod_q;
	logic [tsas_pkg::DIVS_W-1:0]       den_q;
	logic [tsas_pkg::MUL_CNT_W-1:0]    mul_cnt_q;
	logic [7:0]                        sx_q;
	logic [tsas_pkg::COORD_W-1:0]      sy_q;

	logic                              out_valid_q;
	logic                              out_status_q;
	logic [tsas_pkg::COORD_W-1:0]      out_x_q;
	logic [tsas_pkg::COORD_W-1:0]      out_y_q;

	logic                              in_req;
	logic                              out_free;
	logic                              div_start;
	logic                              load_release;
	logic                              load_coord;
	logic [tsas_pkg::DIVD_W-1:0]       div_dividend;
	logic [tsas_pkg::DIVS_W-1:0]       div_divisor;
	logic [tsas_pkg::DIVD_W-1:0]       div_quotient;
	tsas_pkg::div_stat_t               div_stat;

	logic [tsas_pkg::RAW_W-1:0]        lo;
	logic [tsas_pkg::RAW_W-1:0]        hi;
	logic [tsas_pkg::RAW_W-1:0]        clamped;
	logic [tsas_pkg::SPAN_W-1:0]       span;
	logic                              bounds_bad;
	logic [tsas_pkg::COORD_W-1:0]      q9;
	logic [tsas_pkg::COORD_W-1:0]      sx9;
	logic [tsas_pkg::COORD_W-1:0]      rot_x;
	logic [tsas_pkg::COORD_W-1:0]      rot_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			max_x_q <= 16'hFFFF;
			min_y_q <= '0;
			max_y_q <= 16'hFFFF;
			scale_x_q <= 8'd240;
			scale_y_q <= 9'd320;
			rot_q <= tsas_pkg::ROT_NORMAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsas_pkg::REG_MIN_X: min_x_q <= cfg_data;
				tsas_pkg::REG_MAX_X: max_x_q <= cfg_data;
				tsas_pkg::REG_MIN_Y: min_y_q <= cfg_data;
				tsas_pkg::REG_MAX_Y: max_y_q <= cfg_data;
				tsas_pkg::REG_SCALE_X: scale_x_q <= cfg_data[7:0];
				tsas_pkg::REG_SCALE_Y: scale_y_q <= cfg_data[8:0];
				tsas_pkg::REG_ROTATION: rot_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Per-axis calibration selection and clamp.
	always_comb begin
		lo = axis_q ? min_y_q : min_x_q;
		hi = axis_q ? max_y_q : max_x_q;
		span = axis_q ? scale_y_q : {1'b0, scale_x_q};
		bounds_bad = (hi <= lo);
		if (avg_q < lo) begin
			clamped = lo;
		end else if (avg_q > hi) begin
			clamped = hi;
		end else begin
			clamped = avg_q;
		end
		q9 = div_quotient[tsas_pkg::COORD_W-1:0];
	end

	always_comb begin
		sx9 = {1'b0, sx_q};
		case (rot_q)
			tsas_pkg::ROT_LEFT: begin
				rot_x = tsas_pkg::SCREEN_LONG - sy_q;
				rot_y = tsas_pkg::SCREEN_SHORT - sx9;
			end
			tsas_pkg::ROT_RIGHT: begin
				rot_x = sy_q;
				rot_y = sx9;
			end
			tsas_pkg::ROT_FLIP: begin
				rot_x = tsas_pkg::SCREEN_SHORT - sx9;
				rot_y = sy_q;
			end
			tsas_pkg::ROT_NORMAL: begin
				rot_x = sx9;
				rot_y = tsas_pkg::SCREEN_LONG - sy_q;
			end
			default: begin
				rot_x = sx9;
				rot_y = tsas_pkg::SCREEN_LONG - sy_q;
			end
		endcase
	end

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			tsas_pkg::ST_IDLE: begin
				if (in_req && s_tuser && cnt_q == LAST_CNT) begin
					state_nx = tsas_pkg::ST_AVG_START;
				end
			end
			tsas_pkg::ST_AVG_START: state_nx = tsas_pkg::ST_AVG_WAIT;
			tsas_pkg::ST_AVG_WAIT: begin
				if (div_stat.done) begin
					state_nx = tsas_pkg::ST_CLAMP;
				end
			end
			tsas_pkg::ST_CLAMP: begin
				if (!bounds_bad) begin
					state_nx = tsas_pkg::ST_MUL;
				end else if (axis_q) begin
					state_nx = tsas_pkg::ST_FINISH;
				end else begin
					state_nx = tsas_pkg::ST_AVG_START;
				end
			end
			tsas_pkg::ST_MUL: begin
				if (mul_cnt_q == LAST_MUL) begin
					state_nx = tsas_pkg::ST_DIV_START;
				end
			end
			tsas_pkg::ST_DIV_START: state_nx = tsas_pkg::ST_DIV_WAIT;
			tsas_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_nx = axis_q ? tsas_pkg::ST_FINISH : tsas_pkg::ST_AVG_START;
				end
			end
			tsas_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nx = tsas_pkg::ST_IDLE;
				end
			end
			default: state_nx = tsas_pkg::ST_IDLE;
		endcase
	end

	// Output and control decode.
	always_comb begin
		out_free = !out_valid_q || m_tready;
		s_tready = (state_q == tsas_pkg::ST_IDLE) && out_free;
		in_req = s_tvalid && s_tready;
		load_release = in_req && !s_tuser;
		load_coord = (state_q == tsas_pkg::ST_FINISH) && out_free;
		div_start = 1'b0;
		div_dividend = prod_q;
		div_divisor = den_q;
		case (state_q)
			tsas_pkg::ST_AVG_START: begin
				div_start = 1'b1;
				div_dividend = axis_q ? tsas_pkg::DIVD_W'(y_sum_q)
					: tsas_pkg::DIVD_W'(x_sum_q);
				div_divisor = tsas_pkg::DIVS_W'(SAMPLES);
			end
			tsas_pkg::ST_DIV_START: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsas_pkg::ST_IDLE;
			x_sum_q <= '0;
			y_sum_q <= '0;
			cnt_q <= '0;
			axis_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_release || load_coord) begin
				x_sum_q <= '0;
				y_sum_q <= '0;
				cnt_q <= '0;
			end else if (in_req) begin
				x_sum_q <= x_sum_q + SUM_W'(s_tdata[15:0]);
				y_sum_q <= y_sum_q + SUM_W'(s_tdata[31:16]);
				cnt_q <= (cnt_q == LAST_CNT) ? '0 : cnt_q + 1'b1;
			end
			if ((state_q == tsas_pkg::ST_CLAMP && bounds_bad) ||
				(state_q == tsas_pkg::ST_DIV_WAIT && div_stat.done)) begin
				axis_q <= ~axis_q;
			end
			if (load_release || load_coord) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tsas_pkg::ST_AVG_WAIT: begin
				if (div_stat.done) begin
					avg_q <= div_quotient[tsas_pkg::RAW_W-1:0];
				end
			end
			tsas_pkg::ST_CLAMP: begin
				mcand_q <= tsas_pkg::DIVD_W'(clamped - lo);
				mplier_q <= span;
				prod_q <= '0;
				den_q <= hi - lo;
				mul_cnt_q <= '0;
				if (bounds_bad) begin
					if (axis_q) begin
						sy_q <= '0;
					end else begin
						sx_q <= '0;
					end
				end
			end
			tsas_pkg::ST_MUL: begin
				if (mplier_q[0]) begin
					prod_q <= prod_q + mcand_q;
				end
				mcand_q <= {mcand_q[tsas_pkg::DIVD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[tsas_pkg::SPAN_W-1:1]};
				mul_cnt_q <= mul_cnt_q + 1'b1;
			end
			tsas_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					if (axis_q) begin
						sy_q <= (q9 > tsas_pkg::SCREEN_LONG) ? tsas_pkg::SCREEN_LONG : q9;
					end else begin
						sx_q <= (q9 > tsas_pkg::SCREEN_SHORT) ? tsas_pkg::SCREEN_SHORT[7:0]
							: q9[7:0];
					end
				end
			end
			default: ;
		endcase
		if (load_release) begin
			out_status_q <= 1'b1;
			out_x_q <= '0;
			out_y_q <= '0;
		end else if (load_coord) begin
			out_status_q <= 1'b0;
			out_x_q <= rot_x;
			out_y_q <= rot_y;
		end
	end

	tsas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.stat     (div_stat)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_status_q;
	assign m_tdata = {6'd0, out_y_q, out_x_q};

`ifndef ASSERT_OFF
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser) |=> (cnt_q == '0 && x_sum_q == '0 && y_sum_q == '0))
		else $error("release did not clear the accumulated state");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("released result carries nonzero coordinates");

	a_scaled_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsas_pkg::ST_FINISH) |->
			({1'b0, sx_q} <= tsas_pkg::SCREEN_SHORT && sy_q <= tsas_pkg::SCREEN_LONG))
		else $error("scaled coordinate above screen span");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for touch_sample_average_scale: stream stimulus, predictor, scoreboard.
module tb_top;

	localparam int unsigned SAMPLES = 16;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 150;
	localparam int unsigned HOLD_CYCLES = 2500;
	localparam int unsigned ITEMS_PER_PHASE = 38;
	localparam int unsigned CAL_PHASES = 6;
	localparam int unsigned RAND_PHASES = 6;
	localparam int unsigned IDLE_PCT = 31;
	localparam int unsigned CALM_PHASE = 1;
	localparam int unsigned HOLD_PHASE = 3;
	localparam bit STATUS_VALID = 1'b0;
	localparam bit STATUS_RELEASED = 1'b1;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int unsigned REG_COUNT = 7;

	typedef struct {
		bit         status;
		logic [8:0] x_coord;
		logic [8:0] y_coord;
	} touch_point_t;

	typedef struct {
		bit          pressed;
		int unsigned reps;
		logic [15:0] x;
		logic [15:0] y;
		bit          typed;
		bit          want_status;
		logic [8:0]  want_x;
		logic [8:0]  want_y;
	} sample_run_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = tsas_pkg::REG_MIN_X;
	logic [15:0] cfg_data = '0;

	touch_point_t points_due[$];
	touch_point_t no_point = '{STATUS_VALID, 9'd0, 9'd0};
	sample_run_t  directed_runs[9];
	logic [15:0]  cal_plan[CAL_PHASES][REG_COUNT];
	logic [15:0]  reg_plan[REG_COUNT];

	logic [15:0] cal_min_x = 16'h0000;
	logic [15:0] cal_max_x = 16'hFFFF;
	logic [15:0] cal_min_y = 16'h0000;
	logic [15:0] cal_max_y = 16'hFFFF;
	logic [7:0]  cal_scale_x = 8'd240;
	logic [8:0]  cal_scale_y = 9'd320;
	logic [1:0]  cal_rotation = tsas_pkg::ROT_NORMAL;
	logic [19:0] sum_x = '0;
	logic [19:0] sum_y = '0;
	int unsigned samples_taken = 0;

	int unsigned samples_sent = 0;
	int unsigned err_count = 0;
	bit          calm = 1'b0;
	bit          hold_go = 1'b0;
	logic        hold_active = 1'b0;

	touch_sample_average_scale #(
		.SAMPLES(SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic logic [8:0] map_axis(input logic [15:0] avg, lo, hi,
			input logic [8:0] span, cap);
		int unsigned a;
		int unsigned v;
		if (hi <= lo) return '0;
		a = avg;
		if (a < lo) a = lo;
		if (a > hi) a = hi;
		v = (a - lo) * span / (hi - lo);
		return (v > cap) ? cap : 9'(v);
	endfunction

	task automatic take_sample(input bit pressed, input logic [15:0] xr, yr,
			output bit emits, output touch_point_t pt);
		logic [8:0] sx;
		logic [8:0] sy;
		emits = 1'b1;
		pt = '{STATUS_RELEASED, 9'd0, 9'd0};
		if (!pressed) begin
			sum_x = '0;
			sum_y = '0;
			samples_taken = 0;
			return;
		end
		sum_x += xr;
		sum_y += yr;
		samples_taken++;
		if (samples_taken < SAMPLES) begin
			emits = 1'b0;
			return;
		end
		sx = map_axis(16'(sum_x / SAMPLES), cal_min_x, cal_max_x, 9'(cal_scale_x),
			tsas_pkg::SCREEN_SHORT);
		sy = map_axis(16'(sum_y / SAMPLES), cal_min_y, cal_max_y, cal_scale_y,
			tsas_pkg::SCREEN_LONG);
		sum_x = '0;
		sum_y = '0;
		samples_taken = 0;
		pt.status = STATUS_VALID;
		case (cal_rotation)
			tsas_pkg::ROT_LEFT: begin
				pt.x_coord = tsas_pkg::SCREEN_LONG - sy;
				pt.y_coord = tsas_pkg::SCREEN_SHORT - sx;
			end
			tsas_pkg::ROT_RIGHT: begin
				pt.x_coord = sy;
				pt.y_coord = sx;
			end
			tsas_pkg::ROT_FLIP: begin
				pt.x_coord = tsas_pkg::SCREEN_SHORT - sx;
				pt.y_coord = sy;
			end
			default: begin
				pt.x_coord = sx;
				pt.y_coord = tsas_pkg::SCREEN_LONG - sy;
			end
		endcase
	endtask

	task automatic send_sample(input bit pressed, input logic [15:0] xr, yr,
			input bit typed, input touch_point_t want);
		bit emits;
		touch_point_t pt;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= pressed;
		s_tdata <= {yr, xr};
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		take_sample(pressed, xr, yr, emits, pt);
		if (emits) points_due.push_back(typed ? want : pt);
	endtask

	function automatic logic [15:0] jitter(input int c);
		int v;
		v = c + int'($urandom_range(0, 1023)) - 512;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return 16'(v);
	endfunction

	task automatic send_release();
		send_sample(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			1'b0, no_point);
	endtask

	task automatic send_set(input int unsigned n);
		int unsigned mode;
		int cx;
		int cy;
		mode = $urandom_range(0, 3);
		cx = $urandom_range(0, 65535);
		cy = $urandom_range(0, 65535);
		if (mode == 2) begin
			cx = $urandom_range(0, 1) ? cal_min_x : cal_max_x;
			cy = $urandom_range(0, 1) ? cal_min_y : cal_max_y;
		end else if (mode == 3) begin
			cx = $urandom_range(0, 1) ? 0 : 65535;
			cy = $urandom_range(0, 1) ? 0 : 65535;
		end
		for (int unsigned i = 0; i < n; i++) begin
			if (mode == 0)
				send_sample(1'b1, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 1'b0, no_point);
			else
				send_sample(1'b1, jitter(cx), jitter(cy), 1'b0, no_point);
		end
	endtask

	task automatic run_phase(input int unsigned quota);
		int unsigned target;
		int unsigned roll;
		target = samples_sent + quota;
		while (samples_sent < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				send_set(SAMPLES - samples_taken);
				if ($urandom_range(0, 3) == 0) send_release();
			end else if (roll < 92) begin
				send_set($urandom_range(1, SAMPLES - 1));
				if ($urandom_range(0, 3) != 0) send_release();
			end else begin
				send_release();
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (points_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tsas_pkg::REG_MIN_X: cal_min_x = val;
			tsas_pkg::REG_MAX_X: cal_max_x = val;
			tsas_pkg::REG_MIN_Y: cal_min_y = val;
			tsas_pkg::REG_MAX_Y: cal_max_y = val;
			tsas_pkg::REG_SCALE_X: cal_scale_x = val[7:0];
			tsas_pkg::REG_SCALE_Y: cal_scale_y = val[8:0];
			tsas_pkg::REG_ROTATION: cal_rotation = val[1:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input bit poke_unused);
		write_reg(tsas_pkg::REG_MIN_X, reg_plan[tsas_pkg::REG_MIN_X]);
		write_reg(tsas_pkg::REG_MAX_X, reg_plan[tsas_pkg::REG_MAX_X]);
		write_reg(tsas_pkg::REG_MIN_Y, reg_plan[tsas_pkg::REG_MIN_Y]);
		write_reg(tsas_pkg::REG_MAX_Y, reg_plan[tsas_pkg::REG_MAX_Y]);
		write_reg(tsas_pkg::REG_SCALE_X, reg_plan[tsas_pkg::REG_SCALE_X]);
		write_reg(tsas_pkg::REG_SCALE_Y, reg_plan[tsas_pkg::REG_SCALE_Y]);
		write_reg(tsas_pkg::REG_ROTATION, reg_plan[tsas_pkg::REG_ROTATION]);
		if (poke_unused) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : take_point
		touch_point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (points_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0b x %0d y %0d",
					m_tuser, m_tdata[8:0], m_tdata[17:9]));
			end else begin
				want = points_due.pop_front();
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status %0b, expected %0b",
						m_tuser, want.status));
				if (m_tdata[8:0] !== want.x_coord)
					report_mismatch($sformatf("x_coord %0d, expected %0d",
						m_tdata[8:0], want.x_coord));
				if (m_tdata[17:9] !== want.y_coord)
					report_mismatch($sformatf("y_coord %0d, expected %0d",
						m_tdata[17:9], want.y_coord));
			end
		end
		m_tready <= !hold_active && (calm || $urandom_range(0, 99) >= IDLE_PCT);
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	initial begin
		touch_point_t want;
		directed_runs = '{
			'{1'b0, 1, 16'h0000, 16'h0000, 1'b1, STATUS_RELEASED, 9'd0, 9'd0},
			'{1'b1, 16, 16'h0000, 16'h0000, 1'b1, STATUS_VALID, 9'd0, 9'd320},
			'{1'b1, 16, 16'hFFFF, 16'hFFFF, 1'b1, STATUS_VALID, 9'd240, 9'd0},
			'{1'b1, 5, 16'h1234, 16'h5678, 1'b0, STATUS_VALID, 9'd0, 9'd0},
			'{1'b0, 1, 16'hFFFF, 16'hFFFF, 1'b1, STATUS_RELEASED, 9'd0, 9'd0},
			'{1'b1, 15, 16'hABCD, 16'h0F0F, 1'b0, STATUS_VALID, 9'd0, 9'd0},
			'{1'b1, 1, 16'h5432, 16'hF0F0, 1'b0, STATUS_VALID, 9'd0, 9'd0},
			'{1'b0, 1, 16'h0000, 16'h0000, 1'b1, STATUS_RELEASED, 9'd0, 9'd0},
			'{1'b1, 16, 16'h8000, 16'h4000, 1'b0, STATUS_VALID, 9'd0, 9'd0}
		};
		cal_plan = '{
			'{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd240, 16'd320,
				16'(tsas_pkg::ROT_LEFT)},
			'{16'h0800, 16'hF000, 16'h1000, 16'hE000, 16'd240, 16'd320,
				16'(tsas_pkg::ROT_RIGHT)},
			'{16'h4000, 16'h4000, 16'h9000, 16'h1000, 16'd200, 16'd300,
				16'(tsas_pkg::ROT_FLIP)},
			'{16'h7000, 16'h7010, 16'h0000, 16'h0001, 16'd255, 16'd511,
				16'(tsas_pkg::ROT_NORMAL)},
			'{16'h0100, 16'hFF00, 16'h0200, 16'hFE00, 16'd0, 16'd0,
				16'(tsas_pkg::ROT_LEFT)},
			'{16'hFFFE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd240, 16'd320,
				16'(tsas_pkg::ROT_FLIP)}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_runs[r]) begin
			want = '{directed_runs[r].want_status, directed_runs[r].want_x,
				directed_runs[r].want_y};
			for (int unsigned k = 0; k < directed_runs[r].reps; k++)
				send_sample(directed_runs[r].pressed, directed_runs[r].x, directed_runs[r].y,
					directed_runs[r].typed && k == directed_runs[r].reps - 1, want);
		end
		settle();

		for (int unsigned p = 0; p < CAL_PHASES + RAND_PHASES; p++) begin
			if (p < CAL_PHASES)
				reg_plan = cal_plan[p];
			else
				foreach (reg_plan[i]) reg_plan[i] = 16'($urandom_range(0, 65535));
			load_regs(p >= CAL_PHASES);
			calm = (p == CALM_PHASE);
			if (p == HOLD_PHASE) hold_go = 1'b1;
			run_phase(ITEMS_PER_PHASE);
			settle();
		end

		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
rtl/tsas_pkg.sv
rtl/tsas_div.sv
rtl/touch_sample_average_scale.sv
dv/tb_top.sv
